[rtl/doubling_arena_allocator_unit_macros.svh]
// Assertion macros used by the arena allocator RTL.
// Each check is clocked on clk and ignored while arst_n is low.
`ifndef DOUBLING_ARENA_ALLOCATOR_UNIT_MACROS_SVH
`define DOUBLING_ARENA_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// The condition must hold at every clock edge.
`define DAAU_CHECK(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("daau check failed");

// The consequent must hold in the cycle after the antecedent.
`define DAAU_CHECK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("daau check failed");

`else

`define DAAU_CHECK(label, cond)
`define DAAU_CHECK_NEXT(label, ante, cons)

`endif

`endif

[rtl/daau_pkg.sv]
package daau_pkg;

	localparam int BASE_W    = 16;
	localparam int AMT_W     = 23;
	localparam int IDX_W     = 4;
	localparam int OUT_IDX_W = 3;
	localparam int OUT_CNT_W = 4;
	// A shrinking base_size can leave a fill above its buffer's size, after which the
	// fill keeps growing, so fills are held far wider than any buffer.
	localparam int FILL_W    = 64;

	typedef enum logic {
		FUNC_ALLOC = 1'b0,
		FUNC_FREE  = 1'b1
	} func_t;

	typedef struct packed {
		func_t            func;
		logic [AMT_W-1:0] amount;
	} req_t;

	typedef struct packed {
		logic                 granted;
		logic [OUT_IDX_W-1:0] buffer_index;
		logic [AMT_W-1:0]     offset;
		logic [OUT_CNT_W-1:0] buffers_open;
	} rsp_t;

	// Request token that walks down the row of buffer cells.
	typedef struct packed {
		logic             valid;
		logic [AMT_W-1:0] amount;
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		logic [AMT_W-1:0] offset;
		logic             new_hit;
		logic [IDX_W-1:0] new_idx;
	} tok_t;

	// Fill update broadcast to all cells.
	typedef struct packed {
		logic             valid;
		logic             clear;
		logic [IDX_W-1:0] index;
		logic [AMT_W-1:0] amount;
	} commit_t;

endpackage

[rtl/daau_cell.sv]
module daau_cell #(
	parameter int CELL_IDX = 0,
	parameter int SIZE_W   = 23
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [daau_pkg::BASE_W-1:0]    base_size,
	input  logic                           is_open,
	input  daau_pkg::tok_t                 tok_in,
	output daau_pkg::tok_t                 tok_out,
	input  daau_pkg::commit_t              commit
);

	localparam int XW = (SIZE_W > daau_pkg::FILL_W) ? SIZE_W : daau_pkg::FILL_W;

	logic [daau_pkg::FILL_W-1:0] fill_q;
	logic [XW-1:0]     size_x;
	logic [XW-1:0]     fill_x;
	logic [XW-1:0]     amt_x;
	logic [XW-1:0]     free_x;
	logic              fits_size;
	logic              fits_open;
	logic              fits_new;
	daau_pkg::tok_t    tok_d;
	daau_pkg::tok_t    tok_q;

	assign size_x = XW'(base_size) << CELL_IDX;
	assign fill_x = XW'(fill_q);
	assign amt_x  = XW'(tok_in.amount);
	assign free_x = size_x - fill_x;

	// Sizes shrink going down the row, and a buffer is only a candidate when its
	// size covers the amount.
	assign fits_size = size_x >= amt_x;
	// A fill left above a shrunken size makes the free tail wrap to a huge value,
	// so such a buffer takes any amount that its size covers.
	assign fits_open = is_open && fits_size && ((fill_x > size_x) || (free_x >= amt_x));
	assign fits_new  = !is_open && fits_size;

	always_comb begin
		tok_d = tok_in;
		// The token moves from the newest buffer down, so the first hit is the newest fit.
		if (tok_in.valid && !tok_in.hit && fits_open) begin
			tok_d.hit     = 1'b1;
			tok_d.hit_idx = daau_pkg::IDX_W'(CELL_IDX);
			tok_d.offset  = fill_x[daau_pkg::AMT_W-1:0];
		end
		// Later cells are smaller, so the last closed fit seen is the lowest one.
		if (tok_in.valid && fits_new) begin
			tok_d.new_hit = 1'b1;
			tok_d.new_idx = daau_pkg::IDX_W'(CELL_IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= '0;
			fill_q <= '0;
		end else begin
			tok_q <= tok_d;
			if (commit.valid && commit.clear) begin
				fill_q <= '0;
			end else if (commit.valid && commit.index == daau_pkg::IDX_W'(CELL_IDX)) begin
				fill_q <= fill_q + daau_pkg::FILL_W'(commit.amount);
			end
		end
	end

	assign tok_out = tok_q;

endmodule

[rtl/doubling_arena_allocator_unit.sv]
// Bump allocator over NUM_BUFFERS buffers, buffer k holding base_size << k bytes.
// Each buffer is a cell in a row that keeps its own fill; an allocate sends a
// token from the newest buffer down to buffer 0, one cell per cycle, and the
// token gathers the newest open buffer with room and the lowest closed buffer
// large enough. An allocate walks its token along the row and then passes
// through ST_FIN; a free_all goes straight to ST_FIN. A new request is taken
// only in ST_IDLE, after the last one is through. A result waits in the output
// register while the next item is accepted. Writing base_size resizes all
// buffers at once and keeps their fills.
`include "doubling_arena_allocator_unit_macros.svh"

module doubling_arena_allocator_unit #(
	parameter int NUM_BUFFERS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [daau_pkg::BASE_W-1:0] cfg_data,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  daau_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output daau_pkg::rsp_t              rsp
);

	localparam int SW    = daau_pkg::BASE_W + NUM_BUFFERS - 1;
	localparam int CNT_W = $clog2(NUM_BUFFERS + 1);
	localparam int CMP_W = daau_pkg::IDX_W + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	state_t                      state_q;
	logic [daau_pkg::BASE_W-1:0] base_size_q;
	logic [CNT_W-1:0]            open_cnt_q;
	daau_pkg::tok_t              entry_q;
	daau_pkg::commit_t           commit_q;
	daau_pkg::rsp_t              res_q;
	daau_pkg::rsp_t              rsp_q;
	logic                        rsp_valid_q;
	daau_pkg::tok_t              chain [NUM_BUFFERS:0];
	logic [NUM_BUFFERS-1:0]      open_vec;
	daau_pkg::tok_t              done_tok;
	logic                        req_fire;
	logic                        alloc_ok;
	logic [CNT_W-1:0]            cnt_next;

	assign cfg_ready = 1'b1;
	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_size_q <= daau_pkg::BASE_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			base_size_q <= cfg_data;
		end
	end

	assign chain[NUM_BUFFERS] = entry_q;

	genvar k;
	generate
		for (k = 0; k < NUM_BUFFERS; k++) begin : g_cell
			assign open_vec[k] = open_cnt_q > CNT_W'(k);

			daau_cell #(
				.CELL_IDX (k),
				.SIZE_W   (SW)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.base_size (base_size_q),
				.is_open   (open_vec[k]),
				.tok_in    (chain[k+1]),
				.tok_out   (chain[k]),
				.commit    (commit_q)
			);
		end
	endgenerate

	assign done_tok = chain[0];
	assign alloc_ok = done_tok.hit || done_tok.new_hit;

	always_comb begin
		if (done_tok.hit) begin
			cnt_next = open_cnt_q;
		end else if (done_tok.new_hit) begin
			cnt_next = CNT_W'(done_tok.new_idx) + CNT_W'(1);
		end else begin
			// Nothing fits: every buffer ends up open.
			cnt_next = CNT_W'(NUM_BUFFERS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			open_cnt_q  <= '0;
			entry_q     <= '0;
			commit_q    <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			entry_q.valid  <= 1'b0;
			commit_q.valid <= 1'b0;
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						if (req.func == daau_pkg::FUNC_FREE) begin
							commit_q.valid <= 1'b1;
							commit_q.clear <= 1'b1;
							open_cnt_q     <= '0;
							res_q          <= '0;
							state_q        <= ST_FIN;
						end else begin
							entry_q        <= '0;
							entry_q.valid  <= 1'b1;
							entry_q.amount <= req.amount;
							state_q        <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (done_tok.valid) begin
						commit_q.valid  <= alloc_ok;
						commit_q.clear  <= 1'b0;
						commit_q.index  <= done_tok.hit ? done_tok.hit_idx : done_tok.new_idx;
						commit_q.amount <= done_tok.amount;
						open_cnt_q      <= cnt_next;
						res_q.granted   <= alloc_ok;
						if (done_tok.hit) begin
							res_q.buffer_index <= done_tok.hit_idx[daau_pkg::OUT_IDX_W-1:0];
							res_q.offset       <= done_tok.offset;
						end else if (done_tok.new_hit) begin
							res_q.buffer_index <= done_tok.new_idx[daau_pkg::OUT_IDX_W-1:0];
							res_q.offset       <= '0;
						end else begin
							res_q.buffer_index <= '0;
							res_q.offset       <= '0;
						end
						res_q.buffers_open <= daau_pkg::OUT_CNT_W'(cnt_next);
						state_q            <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A buffer with room must already be open.
	`DAAU_CHECK(a_hit_is_open, !(done_tok.valid && done_tok.hit) || (CMP_W'(done_tok.hit_idx) < CMP_W'(open_cnt_q)))
	// A buffer chosen for opening must still be closed.
	`DAAU_CHECK(a_new_is_closed, !(done_tok.valid && done_tok.new_hit) || (CMP_W'(done_tok.new_idx) >= CMP_W'(open_cnt_q)))
	// No request is taken while a token is on the row.
	`DAAU_CHECK(a_no_accept_in_scan, !(req_ready && (entry_q.valid || done_tok.valid)))
	// A free_all closes every buffer.
	`DAAU_CHECK_NEXT(a_free_closes, req_fire && (req.func == daau_pkg::FUNC_FREE), open_cnt_q == '0)

endmodule
